// ===== src/vector3_alu_assert.svh =====
// Assertion macros for the vector3_alu RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef VECTOR3_ALU_ASSERT_SVH
`define VECTOR3_ALU_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define V3A_AST_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("vector3_alu check failed");

// Next-cycle implication, disabled while reset is low
`define V3A_AST_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("vector3_alu check failed");

`endif

// ===== src/v3alu_pkg.sv =====
// Shared types and codes for the 3D vector ALU.
// Used by the top level and the lane; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package v3alu_pkg;

  localparam int FIELD_BITS    = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  typedef logic signed [FIELD_BITS-1:0] field_t;

  // operation codes
  typedef enum logic [3:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_ADD_S = 4'd2,
    CMD_SUB_S = 4'd3,
    CMD_MUL_S = 4'd4,
    CMD_DIV_S = 4'd5,
    CMD_LEN   = 4'd6,
    CMD_DOT   = 4'd7,
    CMD_NORM  = 4'd8,
    CMD_CROSS = 4'd9
  } cmd_t;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic [3:0] command;
    field_t     a_x;
    field_t     a_y;
    field_t     a_z;
    logic       a_point;
    field_t     b_x;
    field_t     b_y;
    field_t     b_z;
    logic       b_point;
    field_t     scalar_in;
  } in_t;

  typedef struct packed {
    field_t     r_x;
    field_t     r_y;
    field_t     r_z;
    logic       r_point;
    field_t     scalar_out;
    logic [1:0] status;
  } out_t;

endpackage

`default_nettype wire

// ===== src/vector3_alu.sv =====
// 3D vector ALU top level: three component lanes, merge/sqrt stage,
// three divider lanes, output register with skid. Uses v3alu_pkg.
//
//   channel | ports                       | moves
//   --------+-----------------------------+------------------------------
//   input   | in_valid in_ready in_data   | one command with A, B, scalar
//   output  | out_valid out_ready out_data| one result vector/scalar/status
//
// One item accepted per cycle while the skid register is empty; the path to the
// output register runs through the input register, the lanes, the merge and
// square-root stages, then the divider stages.
// All stages advance together; a transfer stalls only when both the output
// register and the skid register are full.
// Reset (rst_n low, synchronous) empties the pipeline and the output side.
`timescale 1ns / 1ps
`default_nettype none
`include "vector3_alu_assert.svh"

module vector3_alu #(
  parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = v3alu_pkg::WORD_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire v3alu_pkg::in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output v3alu_pkg::out_t      out_data
);

  localparam int E   = (WORD_BITS < v3alu_pkg::FIELD_BITS) ? WORD_BITS
                                                            : v3alu_pkg::FIELD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int TOT = 4 + 2*E + F;
  localparam logic signed [E+F:0] DMAX = {{(F+2){1'b0}}, {(E-1){1'b1}}};
  localparam logic signed [E+F:0] DMIN = {{(F+2){1'b1}}, {(E-1){1'b0}}};

  typedef struct packed {
    logic [3:0]          cmd;
    logic                rp;
    logic signed [E-1:0] a0;
    logic signed [E-1:0] a1;
    logic signed [E-1:0] a2;
    logic signed [E-1:0] s;
  } sda_t;

  typedef struct packed {
    logic [3:0]   cmd;
    logic         rp;
    logic         dz;
    logic [E-1:0] len;
  } sdb_t;

  typedef struct packed {
    logic signed [E-1:0] v0;
    logic signed [E-1:0] v1;
    logic signed [E-1:0] v2;
    logic                sat;
  } sdv_t;

  typedef struct packed {
    logic signed [E-1:0] dot;
    logic                sat;
  } sds_t;

  logic            adv;
  logic [TOT-1:0]  vld_r;
  sda_t            st0_r, sda_nxt, sda_q;
  logic signed [E-1:0] b_r [3];
  logic signed [E-1:0] a_e [3];

  // output side registers
  v3alu_pkg::out_t out_r, sk_r;
  logic            out_v_r, sk_v_r;
  logic            push, pop;

  assign adv      = !sk_v_r;
  assign in_ready = adv;

  // input stage: wrap operands to the element width, resolve result flag
  always_comb begin
    sda_nxt.cmd = in_data.command;
    sda_nxt.a0  = in_data.a_x[E-1:0];
    sda_nxt.a1  = in_data.a_y[E-1:0];
    sda_nxt.a2  = in_data.a_z[E-1:0];
    sda_nxt.s   = in_data.scalar_in[E-1:0];
    case (in_data.command)
      v3alu_pkg::CMD_ADD, v3alu_pkg::CMD_CROSS:
        sda_nxt.rp = in_data.a_point | in_data.b_point;
      v3alu_pkg::CMD_SUB:
        sda_nxt.rp = in_data.a_point ^ in_data.b_point;
      v3alu_pkg::CMD_ADD_S, v3alu_pkg::CMD_SUB_S, v3alu_pkg::CMD_MUL_S,
      v3alu_pkg::CMD_DIV_S, v3alu_pkg::CMD_NORM:
        sda_nxt.rp = in_data.a_point;
      default:
        sda_nxt.rp = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st0_r  <= sda_nxt;
      b_r[0] <= in_data.b_x[E-1:0];
      b_r[1] <= in_data.b_y[E-1:0];
      b_r[2] <= in_data.b_z[E-1:0];
    end
  end

  assign a_e[0] = st0_r.a0;
  assign a_e[1] = st0_r.a1;
  assign a_e[2] = st0_r.a2;

  // component lanes
  logic signed [E-1:0]   lv   [3];
  logic                  lsat [3];
  logic signed [2*E-1:0] lp   [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3alu_lane #(.E(E), .F(F)) u_lane (
      .clk  (clk),
      .en   (adv),
      .cmd  (st0_r.cmd),
      .a    (a_e[i]),
      .b    (b_r[i]),
      .s    (st0_r.s),
      .c1   (a_e[(i+1)%3]),
      .c2   (b_r[(i+2)%3]),
      .c3   (a_e[(i+2)%3]),
      .c4   (b_r[(i+1)%3]),
      .vec  (lv[i]),
      .vsat (lsat[i]),
      .prod (lp[i])
    );
  end

  // merge: dot product and length
  logic signed [E-1:0] dot_m;
  logic                dsat_m;
  logic [E-1:0]        len_m;

  v3alu_merge #(.E(E), .F(F)) u_merge (
    .clk     (clk),
    .en      (adv),
    .prod    (lp),
    .dot     (dot_m),
    .dot_sat (dsat_m),
    .len     (len_m)
  );

  // side data alongside lanes and square root
  logic [$bits(sda_t)-1:0] dA_q;
  v3alu_dly #(.W($bits(sda_t)), .N(3 + E)) u_dly_a (
    .clk (clk), .en (adv), .d (st0_r), .q (dA_q)
  );
  assign sda_q = dA_q;

  // divider setup: divisor is |scalar| or the length
  logic [E-1:0] den;
  logic         den_neg;
  sdb_t         sdb_nxt, sdb_q;
  logic signed [E-1:0] num [3];

  assign num[0] = sda_q.a0;
  assign num[1] = sda_q.a1;
  assign num[2] = sda_q.a2;

  always_comb begin
    den     = (sda_q.cmd == v3alu_pkg::CMD_NORM) ? len_m
            : (sda_q.s[E-1] ? (~sda_q.s + 1'b1) : sda_q.s);
    den_neg = (sda_q.cmd == v3alu_pkg::CMD_DIV_S) && sda_q.s[E-1];
    sdb_nxt.cmd = sda_q.cmd;
    sdb_nxt.rp  = sda_q.rp;
    sdb_nxt.len = len_m;
    sdb_nxt.dz  = ((sda_q.cmd == v3alu_pkg::CMD_DIV_S) && (sda_q.s == '0)) ||
                  ((sda_q.cmd == v3alu_pkg::CMD_NORM) && (len_m == '0));
  end

  logic [E+F-1:0] quo [3];
  logic           qng [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3alu_div #(.E(E), .F(F)) u_div (
      .clk     (clk),
      .en      (adv),
      .num     (num[i]),
      .den     (den),
      .den_neg (den_neg),
      .quo     (quo[i]),
      .neg     (qng[i])
    );
  end

  logic [$bits(sdb_t)-1:0] dB_q;
  v3alu_dly #(.W($bits(sdb_t)), .N(E + F)) u_dly_b (
    .clk (clk), .en (adv), .d (sdb_nxt), .q (dB_q)
  );
  assign sdb_q = dB_q;

  sdv_t sdv_nxt, sdv_q;
  logic [$bits(sdv_t)-1:0] dV_q;
  assign sdv_nxt = '{v0: lv[0], v1: lv[1], v2: lv[2],
                     sat: lsat[0] | lsat[1] | lsat[2]};
  v3alu_dly #(.W($bits(sdv_t)), .N(1 + 2*E + F)) u_dly_v (
    .clk (clk), .en (adv), .d (sdv_nxt), .q (dV_q)
  );
  assign sdv_q = dV_q;

  sds_t sds_nxt, sds_q;
  logic [$bits(sds_t)-1:0] dS_q;
  assign sds_nxt = '{dot: dot_m, sat: dsat_m};
  v3alu_dly #(.W($bits(sds_t)), .N(2*E + F)) u_dly_s (
    .clk (clk), .en (adv), .d (sds_nxt), .q (dS_q)
  );
  assign sds_q = dS_q;

  // final selection: signed quotient clamp and per-command result
  logic signed [E+F:0] qv   [3];
  logic signed [E-1:0] dres [3];
  logic                dsat [3];
  logic signed [E-1:0] rv   [3];
  logic signed [E-1:0] sc;
  logic                sat;
  v3alu_pkg::out_t     out_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qv[i] = qng[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
      if (qv[i] > DMAX) begin
        dres[i] = DMAX[E-1:0];
        dsat[i] = 1'b1;
      end else if (qv[i] < DMIN) begin
        dres[i] = DMIN[E-1:0];
        dsat[i] = 1'b1;
      end else begin
        dres[i] = qv[i][E-1:0];
        dsat[i] = 1'b0;
      end
      rv[i] = '0;
    end
    sc  = '0;
    sat = 1'b0;
    case (sdb_q.cmd)
      v3alu_pkg::CMD_ADD, v3alu_pkg::CMD_SUB, v3alu_pkg::CMD_ADD_S,
      v3alu_pkg::CMD_SUB_S, v3alu_pkg::CMD_MUL_S, v3alu_pkg::CMD_CROSS: begin
        rv[0] = sdv_q.v0;
        rv[1] = sdv_q.v1;
        rv[2] = sdv_q.v2;
        sat   = sdv_q.sat;
      end
      v3alu_pkg::CMD_DIV_S, v3alu_pkg::CMD_NORM: begin
        if (!sdb_q.dz) begin
          rv  = dres;
          sat = dsat[0] | dsat[1] | dsat[2];
        end
      end
      v3alu_pkg::CMD_LEN: begin
        if (sdb_q.len[E-1]) begin
          sc  = {1'b0, {(E-1){1'b1}}};
          sat = 1'b1;
        end else begin
          sc  = sdb_q.len;
        end
      end
      v3alu_pkg::CMD_DOT: begin
        sc  = sds_q.dot;
        sat = sds_q.sat;
      end
      default: ;
    endcase
    out_nxt.r_x        = v3alu_pkg::field_t'(rv[0]);
    out_nxt.r_y        = v3alu_pkg::field_t'(rv[1]);
    out_nxt.r_z        = v3alu_pkg::field_t'(rv[2]);
    out_nxt.r_point    = sdb_q.rp;
    out_nxt.scalar_out = v3alu_pkg::field_t'(sc);
    out_nxt.status     = sdb_q.dz ? v3alu_pkg::ST_DIVZ
                       : sat      ? v3alu_pkg::ST_SAT : v3alu_pkg::ST_OK;
  end

  // output register plus skid register
  assign push = vld_r[TOT-1] & adv;
  assign pop  = out_v_r & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      if (adv) begin
        vld_r <= {vld_r[TOT-2:0], in_valid};
      end
      if (sk_v_r) begin
        if (pop) begin
          sk_v_r <= 1'b0;
        end
      end else if (push) begin
        if (!out_v_r || pop) begin
          out_v_r <= 1'b1;
        end else begin
          sk_v_r <= 1'b1;
        end
      end else if (pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sk_v_r) begin
      if (pop) begin
        out_r <= sk_r;
      end
    end else if (push) begin
      if (!out_v_r || pop) begin
        out_r <= out_nxt;
      end else begin
        sk_r <= out_nxt;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // checks
  logic out_vec_zero, out_divz, out_scl_nz;

  assign out_vec_zero = (out_r.r_x == '0) && (out_r.r_y == '0) && (out_r.r_z == '0);
  assign out_divz     = out_v_r && (out_r.status == v3alu_pkg::ST_DIVZ);
  assign out_scl_nz   = out_v_r && (out_r.scalar_out != '0);

  `V3A_AST_IMP(a_skid_has_out, clk, rst_n, sk_v_r, out_v_r)
  `V3A_AST_NXT(a_stall_holds, clk, rst_n, !adv, $stable(vld_r))
  `V3A_AST_IMP(a_divz_zero, clk, rst_n, out_divz, out_vec_zero && out_r.scalar_out == '0)
  `V3A_AST_IMP(a_scalar_novec, clk, rst_n, out_scl_nz, out_vec_zero && !out_r.r_point)

endmodule

`default_nettype wire

// ===== src/v3alu_dly.sv =====
// Fixed-length shift line for side data that travels beside the lanes.
// Generic; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module v3alu_dly #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] sh_r [N];

  // shift on every pipeline advance
  always_ff @(posedge clk) begin
    if (en) begin
      sh_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        sh_r[i] <= sh_r[i-1];
      end
    end
  end

  assign q = sh_r[N-1];

endmodule

`default_nettype wire

// ===== src/v3alu_lane.sv =====
// One component lane: add/sub, scalar ops, products and cross term, saturated.
// Two register stages. Depends on v3alu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module v3alu_lane #(
  parameter int E = 32,
  parameter int F = 16
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [3:0]            cmd,
  input  wire logic signed [E-1:0]   a,
  input  wire logic signed [E-1:0]   b,
  input  wire logic signed [E-1:0]   s,
  input  wire logic signed [E-1:0]   c1,
  input  wire logic signed [E-1:0]   c2,
  input  wire logic signed [E-1:0]   c3,
  input  wire logic signed [E-1:0]   c4,
  output logic signed [E-1:0]        vec,
  output logic                       vsat,
  output logic signed [2*E-1:0]      prod
);

  localparam int QW = 2*E - F;
  localparam int VW = 2*E + 2;
  localparam logic signed [VW-1:0] EMAX = {{(VW-E+1){1'b0}}, {(E-1){1'b1}}};
  localparam logic signed [VW-1:0] EMIN = {{(VW-E+1){1'b1}}, {(E-1){1'b0}}};
  localparam logic signed [F+1:0]  HALF = {2'b00, 1'b1, {(F-1){1'b0}}};

  logic signed [E-1:0]   m1a, m1b;
  logic signed [E:0]     as_nxt;
  logic signed [2*E-1:0] p1_r, p2_r;
  logic signed [E:0]     as_r;
  logic [3:0]            cmd_r;

  // operand select for the main multiplier
  always_comb begin
    case (cmd)
      v3alu_pkg::CMD_MUL_S: begin
        m1a = a;  m1b = s;
      end
      v3alu_pkg::CMD_LEN, v3alu_pkg::CMD_NORM: begin
        m1a = a;  m1b = a;
      end
      v3alu_pkg::CMD_CROSS: begin
        m1a = c1; m1b = c2;
      end
      default: begin
        m1a = a;  m1b = b;
      end
    endcase
  end

  // add / subtract path
  always_comb begin
    case (cmd)
      v3alu_pkg::CMD_ADD:   as_nxt = (E+1)'(a) + (E+1)'(b);
      v3alu_pkg::CMD_SUB:   as_nxt = (E+1)'(a) - (E+1)'(b);
      v3alu_pkg::CMD_ADD_S: as_nxt = (E+1)'(a) + (E+1)'(s);
      v3alu_pkg::CMD_SUB_S: as_nxt = (E+1)'(a) - (E+1)'(s);
      default:              as_nxt = '0;
    endcase
  end

  // stage A: products
  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= m1a * m1b;
      p2_r  <= c3 * c4;
      as_r  <= as_nxt;
      cmd_r <= cmd;
    end
  end

  // stage B: rounding of products and the cross difference, then clamp
  logic signed [QW-1:0] q1, q2;
  logic [F-1:0]         r1, r2;
  logic signed [F+1:0]  dfr;
  logic signed [1:0]    adj;
  logic signed [VW-1:0] mulv, crsv, val;
  logic                 use_v;

  assign q1   = p1_r[2*E-1:F];
  assign q2   = p2_r[2*E-1:F];
  assign r1   = p1_r[F-1:0];
  assign r2   = p2_r[F-1:0];
  assign dfr  = $signed({2'b00, r1}) - $signed({2'b00, r2}) + HALF;
  assign adj  = dfr[F+1:F];
  assign mulv = VW'(q1) + VW'($signed({1'b0, r1[F-1]}));
  assign crsv = VW'(q1) - VW'(q2) + VW'(adj);

  always_comb begin
    use_v = 1'b1;
    case (cmd_r)
      v3alu_pkg::CMD_ADD, v3alu_pkg::CMD_SUB,
      v3alu_pkg::CMD_ADD_S, v3alu_pkg::CMD_SUB_S: val = VW'(as_r);
      v3alu_pkg::CMD_MUL_S:                       val = mulv;
      v3alu_pkg::CMD_CROSS:                       val = crsv;
      default: begin
        val   = '0;
        use_v = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= p1_r;
      if (val > EMAX) begin
        vec  <= EMAX[E-1:0];
        vsat <= use_v;
      end else if (val < EMIN) begin
        vec  <= EMIN[E-1:0];
        vsat <= use_v;
      end else begin
        vec  <= val[E-1:0];
        vsat <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/v3alu_merge.sv =====
// Merge stage: rounded dot product over the three lanes, sum of squares,
// and a bit-per-stage square root pipeline. No package use.
`timescale 1ns / 1ps
`default_nettype none

module v3alu_merge #(
  parameter int E = 32,
  parameter int F = 16
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic signed [2*E-1:0]   prod [3],
  output logic signed [E-1:0]          dot,
  output logic                         dot_sat,
  output logic [E-1:0]                 len
);

  localparam int QW = 2*E - F;
  localparam int VW = 2*E + 2;
  localparam logic signed [VW-1:0] EMAX = {{(VW-E+1){1'b0}}, {(E-1){1'b1}}};
  localparam logic signed [VW-1:0] EMIN = {{(VW-E+1){1'b1}}, {(E-1){1'b0}}};
  localparam logic [F+1:0]         HALF = {2'b00, 1'b1, {(F-1){1'b0}}};

  logic signed [QW+1:0] qs;
  logic [F+1:0]         rs;
  logic signed [VW-1:0] dotv;
  logic [2*E-1:0]       sum_r;

  // dot: sum of floors plus rounded sum of fractions
  always_comb begin
    qs = '0;
    rs = HALF;
    for (int i = 0; i < 3; i++) begin
      qs = qs + (QW+2)'($signed(prod[i][2*E-1:F]));
      rs = rs + (F+2)'(prod[i][F-1:0]);
    end
    dotv = VW'(qs) + VW'($signed({1'b0, rs[F+1:F]}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= $unsigned(prod[0]) + $unsigned(prod[1]) + $unsigned(prod[2]);
      if (dotv > EMAX) begin
        dot     <= EMAX[E-1:0];
        dot_sat <= 1'b1;
      end else if (dotv < EMIN) begin
        dot     <= EMIN[E-1:0];
        dot_sat <= 1'b1;
      end else begin
        dot     <= dotv[E-1:0];
        dot_sat <= 1'b0;
      end
    end
  end

  // square root: one result bit per stage, two radicand bits consumed
  logic [E-1:0]   rm_in [E];
  logic [E-1:0]   rt_in [E];
  logic [2*E-1:0] nn_in [E];
  logic [E+1:0]   rs_c  [E];
  logic [E+1:0]   tr_c  [E];
  logic [E+1:0]   rm_c  [E];
  logic           ge_c  [E];
  logic [E-1:0]   rm_r  [E-1];
  logic [2*E-1:0] nn_r  [E-1];
  logic [E-1:0]   rt_r  [E];

  always_comb begin
    rm_in[0] = '0;
    rt_in[0] = '0;
    nn_in[0] = sum_r;
    for (int i = 1; i < E; i++) begin
      rm_in[i] = rm_r[i-1];
      rt_in[i] = rt_r[i-1];
      nn_in[i] = nn_r[i-1];
    end
    for (int i = 0; i < E; i++) begin
      rs_c[i] = {rm_in[i], nn_in[i][2*E-1:2*E-2]};
      tr_c[i] = {rt_in[i], 2'b01};
      ge_c[i] = rs_c[i] >= tr_c[i];
      rm_c[i] = ge_c[i] ? (rs_c[i] - tr_c[i]) : rs_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < E; i++) begin
        rt_r[i] <= {rt_in[i][E-2:0], ge_c[i]};
      end
      for (int i = 0; i < E-1; i++) begin
        rm_r[i] <= rm_c[i][E-1:0];
        nn_r[i] <= {nn_in[i][2*E-3:0], 2'b00};
      end
    end
  end

  assign len = rt_r[E-1];

endmodule

`default_nettype wire

// ===== src/v3alu_div.sv =====
// Pipelined restoring divider for one lane: |num| * 2^F / den, one
// quotient bit per stage, sign applied by the caller. No package use.
`timescale 1ns / 1ps
`default_nettype none

module v3alu_div #(
  parameter int E = 32,
  parameter int F = 16
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [E-1:0] num,
  input  wire logic [E-1:0]        den,
  input  wire logic                den_neg,
  output logic [E+F-1:0]           quo,
  output logic                     neg
);

  localparam int N = E + F;

  logic [E-1:0] mag;
  logic [E-1:0] rem_in [N];
  logic [N-1:0] nq_in  [N];
  logic [E-1:0] dd_in  [N];
  logic         ng_in  [N];
  logic [E:0]   tr_c   [N];
  logic         ge_c   [N];
  logic [E-1:0] rem_r  [N-1];
  logic [E-1:0] dd_r   [N-1];
  logic [N-1:0] nq_r   [N];
  logic         ng_r   [N];

  assign mag = num[E-1] ? (~num + 1'b1) : num;

  always_comb begin
    rem_in[0] = '0;
    nq_in[0]  = {mag, {F{1'b0}}};
    dd_in[0]  = den;
    ng_in[0]  = num[E-1] ^ den_neg;
    for (int i = 1; i < N; i++) begin
      rem_in[i] = rem_r[i-1];
      nq_in[i]  = nq_r[i-1];
      dd_in[i]  = dd_r[i-1];
      ng_in[i]  = ng_r[i-1];
    end
    for (int i = 0; i < N; i++) begin
      tr_c[i] = {rem_in[i], nq_in[i][N-1]};
      ge_c[i] = tr_c[i] >= {1'b0, dd_in[i]};
    end
  end

  // one trial subtraction per stage
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        nq_r[i] <= {nq_in[i][N-2:0], ge_c[i]};
        ng_r[i] <= ng_in[i];
      end
      for (int i = 0; i < N-1; i++) begin
        rem_r[i] <= ge_c[i] ? E'(tr_c[i] - {1'b0, dd_in[i]}) : tr_c[i][E-1:0];
        dd_r[i]  <= dd_in[i];
      end
    end
  end

  assign quo = nq_r[N-1];
  assign neg = ng_r[N-1];

endmodule

`default_nettype wire
